>>> sv/rri_pkg.sv
// Shared constants for the video DAC register block: opcodes, port codes,
// register addresses, ID values and cursor offsets. No dependencies.
`default_nettype none
package rri_pkg;

   // input opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_IACK  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // host ports
   localparam logic [2:0] P_LOW  = 3'd0;
   localparam logic [2:0] P_HIGH = 3'd1;
   localparam logic [2:0] P_REG  = 3'd2;
   localparam logic [2:0] P_PAL  = 3'd3;

   // configuration register indexes
   localparam logic [1:0] CFG_WIDE   = 2'd0;
   localparam logic [1:0] CFG_BOARD  = 2'd1;
   localparam logic [1:0] CFG_IRQP   = 2'd2;
   localparam logic [1:0] CFG_PERIOD = 2'd3;

   // board kinds
   localparam logic [1:0] BK_OFFSET = 2'd1;
   localparam logic [1:0] BK_NOIRQ  = 2'd2;

   // register addresses
   localparam logic [15:0] A_ID   = 16'h0200;
   localparam logic [15:0] A_PRM  = 16'h0204;
   localparam logic [15:0] A_CCR  = 16'h0300;
   localparam logic [15:0] A_CXLO = 16'h0301;
   localparam logic [15:0] A_CXHI = 16'h0302;
   localparam logic [15:0] A_CYLO = 16'h0303;
   localparam logic [15:0] A_CYHI = 16'h0304;

   localparam logic [31:0] ID_WIDE   = 32'h004a4a4a;
   localparam logic [31:0] ID_NARROW = 32'h004a0000;

   localparam logic [7:0] CCR_OFF  = 8'h00;
   localparam logic [7:0] CCR_ON0  = 8'hc0;
   localparam logic [7:0] CCR_ON1  = 8'hc1;

   localparam logic signed [17:0] X_OFF   = 18'sd370;
   localparam logic signed [17:0] Y_OFF   = 18'sd37;
   localparam logic signed [17:0] X_BOARD = 18'sd150;
   localparam logic signed [17:0] Y_BOARD = 18'sd14;
   localparam logic signed [17:0] Y_FLIP  = 18'sd5;

   localparam logic [15:0] RETRACE_RESET = 16'd10000;
   localparam logic [6:0]  CUR_DIM_RESET = 7'd8;

endpackage
`default_nettype wire

>>> sv/ramdac_register_interface_top.sv
// Video DAC register block top: host access sequencer around the register
// and palette RAMs. Uses rri_pkg, rri_store and rri_scan.
// Tick and interrupt-ack are answered from idle; a port access first wraps the
// address (one subtract per cycle, up to 15 at the defaults), then may do one RAM read.
// A cursor RAM write adds a rescan of CURSOR_DIM*ceil(CURSOR_DIM/4) bytes, one per
// cycle through the register RAM read port (1024 bytes at the defaults).
// One item in flight; the next transfer is taken in idle with the result register free.
// Reset: synchronous; a zeroing sweep of both RAMs runs before the first item.
`default_nettype none
module ramdac_register_interface_top
   import rri_pkg::*;
#(
   parameter int NUM_REGS        = 4096,
   parameter int CURSOR_RAM_BASE = 1024,
   parameter int PALETTE_ENTRIES = 256,
   parameter int CURSOR_DIM      = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // port[2:0], write_data[34:3], byte_access[35], zero fill
   input  wire logic [39:0] req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], irq_line[32], video_enabled[33], redraw_request[34],
   // cursor_update[35], cursor_xpos[52:36], cursor_ypos[69:53],
   // cursor_visible[70], cursor_width[77:71], cursor_height[84:78], zero fill
   output logic [87:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int RA_W      = $clog2(NUM_REGS);
   localparam int PAL_DEPTH = PALETTE_ENTRIES * 3;
   localparam int PA_W      = $clog2(PAL_DEPTH);
   localparam int CB        = (CURSOR_DIM + 3) / 4;
   localparam int RSTEP     = CURSOR_DIM / 4;
   localparam int COL_W     = $clog2(CB);
   localparam int ROW_W     = $clog2(CURSOR_DIM);
   localparam int OFF_W     = $clog2(RSTEP * CURSOR_DIM + 1);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MOD  = 4'd2;
   localparam logic [3:0] S_ACC  = 4'd3;
   localparam logic [3:0] S_RDW  = 4'd4;
   localparam logic [3:0] S_PALW = 4'd5;
   localparam logic [3:0] S_SCAN = 4'd6;
   localparam logic [3:0] S_CUR  = 4'd7;

   // configuration
   logic        wide_ff, irqp_ff;
   logic [1:0]  bk_ff;
   logic [15:0] period_ff;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [2:0]  port_ff, port_in;
   logic [31:0] wd_ff, wd_in;
   logic        byte_ff, byte_in;
   logic [15:0] ba_ff, ba_in;
   logic [7:0]  al_ff, al_in, ah_ff, ah_in;
   logic [1:0]  comp_ff, comp_in;
   logic        video_ff, video_in, cen_ff, cen_in, old_on_ff, old_on_in;
   logic signed [17:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [6:0]  cur_w_ff, cur_w_in, cur_h_ff, cur_h_in;
   logic        armed_ff, armed_in, irq_ff, irq_in;
   logic [15:0] rcount_ff, rcount_in;
   logic [31:0] id_ff, id_in;
   logic        ccr0_ff, ccr0_in;
   logic [7:0]  cxlo_ff, cxlo_in, cxhi_ff, cxhi_in, cylo_ff, cylo_in, cyhi_ff, cyhi_in;
   logic [31:0] rd_ff, rd_in;
   logic        redraw_ff, redraw_in;
   logic [PA_W-1:0] k_ff, k_in;
   logic        scan_go_ff, scan_go_in;
   logic [COL_W-1:0] col_ff, col_in, iss_col_ff, iss_col_in;
   logic [ROW_W-1:0] row_ff, row_in, iss_row_ff, iss_row_in;
   logic [OFF_W-1:0] rowbase_ff, rowbase_in;
   logic        iss_v_ff, iss_v_in, iss_id_ff, iss_id_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [87:0] rsp_data_ff, rsp_data_in;

   logic            rf_we, rf_ready, pal_we, pal_ready;
   logic [RA_W-1:0] rf_waddr, rf_raddr;
   logic [31:0]     rf_wdata, rf_rdata;
   logic [PA_W-1:0] pal_waddr, pal_raddr;
   logic [7:0]      pal_wdata, pal_rdata;

   logic        scan_clr;
   logic [6:0]  xmax, ymax;
   logic [7:0]  scan_byte;

   logic        req_fire, load_rsp, wr, upd;
   logic [31:0] res_rd;
   logic        res_redraw;
   logic [RA_W-1:0] bal;
   logic [RA_W:0]   saddr_full;
   logic [RA_W-1:0] saddr;
   logic [1:0]  ci;
   logic [9:0]  kk;
   logic signed [17:0] nx, ny;

   rri_store #(.DEPTH(NUM_REGS), .WIDTH(32)) u_regs (
      .clock(clock), .reset(reset), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(rf_raddr), .rdata(rf_rdata), .ready(rf_ready)
   );

   rri_store #(.DEPTH(PAL_DEPTH), .WIDTH(8)) u_pal (
      .clock(clock), .reset(reset), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
      .raddr(pal_raddr), .rdata(pal_rdata), .ready(pal_ready)
   );

   assign scan_byte = iss_id_ff ? id_ff[7:0] : rf_rdata[7:0];

   rri_scan #(.COL_W(COL_W), .ROW_W(ROW_W)) u_scan (
      .clock(clock), .clear(scan_clr), .in_valid(iss_v_ff), .data(scan_byte),
      .col(iss_col_ff), .row(iss_row_ff), .xmax(xmax), .ymax(ymax)
   );

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign wr         = (op_ff == OP_WRITE);
   assign bal        = ba_ff[RA_W-1:0];

   always_comb begin
      saddr_full = (RA_W+1)'(CURSOR_RAM_BASE) + (RA_W+1)'(rowbase_ff) + (RA_W+1)'(col_ff);
      if (saddr_full >= (RA_W+1)'(NUM_REGS)) begin
         saddr_full = saddr_full - (RA_W+1)'(NUM_REGS);
      end
      saddr = saddr_full[RA_W-1:0];
      ci    = (comp_ff == 2'd3) ? 2'd2 : comp_ff;
      kk    = {2'b00, ba_ff[7:0]} + {1'b0, ba_ff[7:0], 1'b0} + 10'(ci);
      nx    = $signed({2'b00, cxhi_ff, cxlo_ff}) - X_OFF;
      ny    = $signed({2'b00, cyhi_ff, cylo_ff}) - Y_OFF;
      if (bk_ff == BK_OFFSET) begin
         nx = nx + X_BOARD;
         ny = ny + Y_BOARD;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      port_in    = port_ff;
      wd_in      = wd_ff;
      byte_in    = byte_ff;
      ba_in      = ba_ff;
      al_in      = al_ff;
      ah_in      = ah_ff;
      comp_in    = comp_ff;
      video_in   = video_ff;
      cen_in     = cen_ff;
      old_on_in  = old_on_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      cur_w_in   = cur_w_ff;
      cur_h_in   = cur_h_ff;
      armed_in   = armed_ff;
      irq_in     = irq_ff;
      rcount_in  = rcount_ff;
      id_in      = id_ff;
      ccr0_in    = ccr0_ff;
      cxlo_in    = cxlo_ff;
      cxhi_in    = cxhi_ff;
      cylo_in    = cylo_ff;
      cyhi_in    = cyhi_ff;
      rd_in      = rd_ff;
      redraw_in  = redraw_ff;
      k_in       = k_ff;
      scan_go_in = scan_go_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rowbase_in = rowbase_ff;
      iss_v_in   = 1'b0;
      iss_col_in = iss_col_ff;
      iss_row_in = iss_row_ff;
      iss_id_in  = iss_id_ff;
      scan_clr   = 1'b0;
      rf_we      = 1'b0;
      rf_waddr   = bal;
      rf_wdata   = wd_ff;
      rf_raddr   = bal;
      pal_we     = 1'b0;
      pal_waddr  = k_ff;
      pal_wdata  = wd_ff[7:0];
      pal_raddr  = k_ff;
      load_rsp   = 1'b0;
      upd        = 1'b0;
      res_rd     = '0;
      res_redraw = 1'b0;

      case (state_ff)
         S_CLR: begin
            if (rf_ready && pal_ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser;
               port_in = req_tdata[2:0];
               byte_in = req_tdata[35];
               wd_in   = req_tdata[35] ? {24'h0, req_tdata[10:3]} : req_tdata[34:3];
               case (req_tuser)
                  OP_TICK: begin
                     if ((bk_ff != BK_NOIRQ) && armed_ff && irqp_ff) begin
                        if (rcount_ff == 16'd0) begin
                           rcount_in = period_ff;
                           irq_in    = 1'b1;
                        end else begin
                           rcount_in = rcount_ff - 16'd1;
                           irq_in    = 1'b0;
                        end
                     end
                     load_rsp = 1'b1;
                  end
                  OP_IACK: begin
                     armed_in = 1'b1;
                     if (irqp_ff) begin
                        irq_in = 1'b0;
                     end
                     load_rsp = 1'b1;
                  end
                  default: begin
                     if (irqp_ff) begin
                        irq_in = 1'b0;
                     end
                     id_in     = wide_ff ? ID_WIDE : ID_NARROW;
                     old_on_in = cen_ff;
                     ba_in     = {ah_ff, al_ff};
                     rd_in     = '0;
                     redraw_in = 1'b0;
                     state_in  = S_MOD;
                  end
               endcase
            end
         end
         S_MOD: begin
            // wrap the host address one subtract per cycle
            if (17'(ba_ff) >= 17'(NUM_REGS)) begin
               ba_in = 16'(17'(ba_ff) - 17'(NUM_REGS));
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_CUR;
            case (port_ff)
               P_LOW: begin
                  if (wr) begin
                     al_in   = wd_ff[7:0];
                     comp_in = 2'd0;
                  end else begin
                     rd_in = {24'h0, al_ff};
                  end
               end
               P_HIGH: begin
                  if (wr) begin
                     ah_in   = wd_ff[7:0];
                     comp_in = 2'd0;
                  end else begin
                     rd_in = {24'h0, ah_ff};
                  end
               end
               P_REG: begin
                  al_in = al_ff + 8'd1;
                  if (al_ff == 8'hff) begin
                     ah_in = ah_ff + 8'd1;
                  end
                  if (wr) begin
                     rf_we = 1'b1;
                     if (ba_ff == A_ID) begin
                        id_in = wd_ff;
                     end
                     if (ba_ff == A_PRM) begin
                        video_in  = (wd_ff[7:0] != 8'h00);
                        redraw_in = 1'b1;
                     end
                     if (ba_ff == A_CCR) begin
                        ccr0_in = wd_ff[0];
                        if (wd_ff[7:0] == CCR_OFF) begin
                           cen_in = 1'b0;
                        end else if ((wd_ff[7:0] == CCR_ON0) || (wd_ff[7:0] == CCR_ON1)) begin
                           cen_in = 1'b1;
                        end
                     end
                     if (ba_ff == A_CXLO) cxlo_in = wd_ff[7:0];
                     if (ba_ff == A_CXHI) cxhi_in = wd_ff[7:0];
                     if (ba_ff == A_CYLO) cylo_in = wd_ff[7:0];
                     if (ba_ff == A_CYHI) cyhi_in = wd_ff[7:0];
                     if (ba_ff >= 16'(CURSOR_RAM_BASE)) begin
                        scan_go_in = 1'b1;
                        col_in     = '0;
                        row_in     = '0;
                        rowbase_in = '0;
                        scan_clr   = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end else begin
                     state_in = S_RDW;
                  end
               end
               P_PAL: begin
                  if (ci == 2'd2) begin
                     comp_in = 2'd0;
                     al_in   = al_ff + 8'd1;
                     if (al_ff == 8'hff) begin
                        ah_in = ah_ff + 8'd1;
                     end
                  end else begin
                     comp_in = ci + 2'd1;
                  end
                  if (ba_ff < 16'(PALETTE_ENTRIES)) begin
                     k_in      = kk[PA_W-1:0];
                     pal_raddr = kk[PA_W-1:0];
                     state_in  = S_PALW;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RDW: begin
            if (ba_ff == A_ID) begin
               rd_in = byte_ff ? {24'h0, id_ff[23:16]} : id_ff;
            end else begin
               rd_in = rf_rdata;
            end
            state_in = S_CUR;
         end
         S_PALW: begin
            if (wr) begin
               pal_we = 1'b1;
               if (video_ff && (pal_rdata != wd_ff[7:0])) begin
                  redraw_in = 1'b1;
               end
            end else begin
               rd_in = {24'h0, pal_rdata};
            end
            state_in = S_CUR;
         end
         S_SCAN: begin
            if (scan_go_ff) begin
               rf_raddr   = saddr;
               iss_v_in   = 1'b1;
               iss_col_in = col_ff;
               iss_row_in = row_ff;
               iss_id_in  = (saddr == RA_W'(A_ID));
               if (col_ff == COL_W'(CB - 1)) begin
                  col_in     = '0;
                  rowbase_in = rowbase_ff + OFF_W'(RSTEP);
                  if (row_ff == ROW_W'(CURSOR_DIM - 1)) begin
                     scan_go_in = 1'b0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else if (!iss_v_ff) begin
               cur_w_in = xmax + 7'd1;
               cur_h_in = ymax + 7'd1;
               state_in = S_CUR;
            end
         end
         S_CUR: begin
            if ((nx != cur_x_ff) || (ny != cur_y_ff) || (cen_ff != old_on_ff)) begin
               cur_x_in = nx;
               cur_y_in = ccr0_ff ? ny : (ny + Y_FLIP - $signed({11'h0, cur_h_ff}));
               upd      = 1'b1;
            end
            if (wr) begin
               res_rd = '0;
            end else if (byte_ff) begin
               res_rd = {24'h0, rd_ff[7:0]};
            end else begin
               res_rd = rd_ff;
            end
            res_redraw = redraw_ff;
            load_rsp   = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in = {3'b000, cur_h_in, cur_w_in, cen_in, cur_y_in[16:0], cur_x_in[16:0],
                     upd, res_redraw, video_in, irq_in, res_rd};
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= 1'b0;
         bk_ff     <= 2'd0;
         irqp_ff   <= 1'b0;
         period_ff <= RETRACE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_WIDE:   wide_ff   <= csr_wdata[0];
            CFG_BOARD:  bk_ff     <= csr_wdata[1:0];
            CFG_IRQP:   irqp_ff   <= csr_wdata[0];
            CFG_PERIOD: period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         al_ff        <= '0;
         ah_ff        <= '0;
         comp_ff      <= '0;
         video_ff     <= 1'b1;
         cen_ff       <= 1'b0;
         old_on_ff    <= 1'b0;
         cur_x_ff     <= -18'sd1;
         cur_y_ff     <= -18'sd1;
         cur_w_ff     <= CUR_DIM_RESET;
         cur_h_ff     <= CUR_DIM_RESET;
         armed_ff     <= 1'b0;
         irq_ff       <= 1'b0;
         rcount_ff    <= '0;
         ccr0_ff      <= 1'b0;
         cxlo_ff      <= '0;
         cxhi_ff      <= '0;
         cylo_ff      <= '0;
         cyhi_ff      <= '0;
         scan_go_ff   <= 1'b0;
         iss_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         al_ff        <= al_in;
         ah_ff        <= ah_in;
         comp_ff      <= comp_in;
         video_ff     <= video_in;
         cen_ff       <= cen_in;
         old_on_ff    <= old_on_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_w_ff     <= cur_w_in;
         cur_h_ff     <= cur_h_in;
         armed_ff     <= armed_in;
         irq_ff       <= irq_in;
         rcount_ff    <= rcount_in;
         ccr0_ff      <= ccr0_in;
         cxlo_ff      <= cxlo_in;
         cxhi_ff      <= cxhi_in;
         cylo_ff      <= cylo_in;
         cyhi_ff      <= cyhi_in;
         scan_go_ff   <= scan_go_in;
         iss_v_ff     <= iss_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      port_ff    <= port_in;
      wd_ff      <= wd_in;
      byte_ff    <= byte_in;
      ba_ff      <= ba_in;
      id_ff      <= id_in;
      rd_ff      <= rd_in;
      redraw_ff  <= redraw_in;
      k_ff       <= k_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      rowbase_ff <= rowbase_in;
      iss_col_ff <= iss_col_in;
      iss_row_ff <= iss_row_in;
      iss_id_ff  <= iss_id_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   a_clear_no_write: assert property (@(posedge clock) disable iff (reset)
      !rf_ready |-> (!rf_we && (state_ff == S_CLR)))
      else $error("host write during clearing sweep");

   a_issue_in_scan: assert property (@(posedge clock) disable iff (reset)
      iss_v_ff |-> (state_ff == S_SCAN))
      else $error("cursor scan data outside scan");

   a_scan_from_reg: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && ($past(state_ff) != S_SCAN)) |->
         ($past(state_ff) == S_ACC) && (port_ff == P_REG) && (op_ff == OP_WRITE))
      else $error("cursor scan started without register write");

endmodule
`default_nettype wire

>>> sv/rri_store.sv
// Generic synchronous RAM with one write port, one registered read port
// and a zeroing sweep after reset. No dependencies.
`default_nettype none
module rri_store #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata,
   output logic                          ready
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] rdata_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff] <= '0;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
   assign ready = !busy_ff;

endmodule
`default_nettype wire

>>> sv/rri_scan.sv
// Cursor bitmap scan accumulator: tracks the rightmost nonzero pixel and
// the lowest nonzero row over a stream of cursor bytes. No dependencies.
`default_nettype none
module rri_scan #(
   parameter int COL_W = 4,
   parameter int ROW_W = 6
) (
   input  wire logic             clock,
   input  wire logic             clear,
   input  wire logic             in_valid,
   input  wire logic [7:0]       data,
   input  wire logic [COL_W-1:0] col,
   input  wire logic [ROW_W-1:0] row,
   output logic      [6:0]       xmax,
   output logic      [6:0]       ymax
);
   logic [6:0] xmax_ff, xmax_in;
   logic [6:0] ymax_ff, ymax_in;
   logic [1:0] pix;
   logic [6:0] cand;

   always_comb begin
      // leftmost pixel sits in the top bits: last nonzero pair wins
      if (data[1:0] != 2'b00) begin
         pix = 2'd3;
      end else if (data[3:2] != 2'b00) begin
         pix = 2'd2;
      end else if (data[5:4] != 2'b00) begin
         pix = 2'd1;
      end else begin
         pix = 2'd0;
      end
      cand    = 7'({col, pix});
      xmax_in = xmax_ff;
      ymax_in = ymax_ff;
      if (clear) begin
         xmax_in = '0;
         ymax_in = '0;
      end else if (in_valid && (data != 8'h00)) begin
         ymax_in = 7'(row);
         if (cand > xmax_ff) begin
            xmax_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      xmax_ff <= xmax_in;
      ymax_ff <= ymax_in;
   end

   assign xmax = xmax_ff;
   assign ymax = ymax_ff;

endmodule
`default_nettype wire
